@@ rtl/sqcf_pkg.sv @@
// Shared package for the square-root continued-fraction period block.
// Holds default sizes, fixed result field widths and the controller/datapath
// command and status structures. Depends on nothing.
package sqcf_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned NUMBER_BITS_DEF = 32;
  localparam int unsigned PERIOD_BITS_DEF = 21;

  // Default divider sizes that follow from the default operand width.
  localparam int unsigned ROOT_BITS_DEF    = (NUMBER_BITS_DEF + 1) / 2;
  localparam int unsigned DIVIDEND_BITS_DEF = 2 * ROOT_BITS_DEF;
  localparam int unsigned DIVISOR_BITS_DEF  = ROOT_BITS_DEF + 1;

  // Fixed port widths of the transaction fields.
  localparam int unsigned NUMBER_W     = 32;
  localparam int unsigned PERIOD_W     = 21;
  localparam int unsigned FIRST_TERM_W = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the operand and seed the root search
    logic root_step;  // one digit of the integer square root
    logic init_rec;   // m = 0, d = 1, a = a0
    logic mul_da;     // product = d * a
    logic sub_m;      // m = product - m
    logic mul_mm;     // product = m * m
    logic div_start;  // launch the shared divider
    logic div_sel_a;  // divider operands: (a0 + m) / d instead of (N - m*m) / d
    logic take_d;     // d = quotient
    logic take_a;     // a = quotient, count one more term
    logic set_sat;    // mark the period counter as clamped
  } sqcf_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic root_last;  // current root step is the final one
    logic perfect;    // root remainder is zero
    logic div_last;   // divider is in its final cycle
    logic q_zero;     // divider quotient is zero
    logic a_end;      // divider quotient equals 2 * a0
    logic cnt_full;   // one more term reaches the counter limit
  } sqcf_status_t;

endpackage

@@ rtl/sqcf_div.sv @@
// Restoring divider producing one quotient bit per cycle.
// Uses no package items beyond default sizes from sqcf_pkg.
module sqcf_div #(
  parameter int unsigned DIVIDEND_BITS = sqcf_pkg::DIVIDEND_BITS_DEF,
  parameter int unsigned DIVISOR_BITS  = sqcf_pkg::DIVISOR_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DIVIDEND_BITS-1:0] dividend_i,
  input  logic [DIVISOR_BITS-1:0]  divisor_i,
  output logic [DIVIDEND_BITS-1:0] quotient_o,
  output logic                     last_o
);

  localparam int unsigned CW = $clog2(DIVIDEND_BITS);

  logic                     run_q, run_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [DIVIDEND_BITS-1:0] dq_q, dq_d;
  logic [DIVISOR_BITS-1:0]  rem_q, rem_d;
  logic [DIVISOR_BITS-1:0]  dvs_q, dvs_d;

  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;
  logic                     ge;

  assign trial  = {rem_q, dq_q[DIVIDEND_BITS-1]};
  assign diff   = trial - {1'b0, dvs_q};
  assign ge     = (trial >= {1'b0, dvs_q});
  assign last_o = run_q && (cnt_q == CW'(DIVIDEND_BITS - 1));

  always_comb begin
    run_d = run_q;
    cnt_d = cnt_q;
    dq_d  = dq_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dq_d  = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
      dq_d  = {dq_q[DIVIDEND_BITS-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (last_o) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = dq_q;

endmodule

@@ rtl/sqcf_dp.sv @@
// Datapath: integer square root, shared multiplier, recurrence registers.
// Depends on sqcf_pkg for command/status types and on sqcf_div.
module sqcf_dp #(
  parameter int unsigned NUMBER_BITS = sqcf_pkg::NUMBER_BITS_DEF,
  parameter int unsigned PERIOD_BITS = sqcf_pkg::PERIOD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [sqcf_pkg::NUMBER_W-1:0]     number_i,
  input  sqcf_pkg::sqcf_cmd_t               cmd_i,
  output sqcf_pkg::sqcf_status_t            status_o,
  output logic [sqcf_pkg::PERIOD_W-1:0]     period_o,
  output logic [sqcf_pkg::FIRST_TERM_W-1:0] first_term_o,
  output logic                              status_flag_o,
  output logic                              saturated_o
);

  localparam int unsigned RB = (NUMBER_BITS + 1) / 2;  // root width
  localparam int unsigned W  = 2 * RB;                 // root search and dividend width
  localparam int unsigned DB = RB + 1;                 // width of d and a
  localparam int unsigned PW = 2 * DB;                 // product width

  logic [NUMBER_BITS-1:0] n_q;
  logic [W-1:0]           v_q, res_q, bit_q;
  logic [RB-1:0]          m_q;
  logic [DB-1:0]          d_q, a_q;
  logic [PW-1:0]          prod_q;
  logic [PERIOD_BITS-1:0] count_q;
  logic                   sat_q;

  logic [RB-1:0]          a0;
  logic [W:0]             root_sum;
  logic                   root_ge;
  logic [DB-1:0]          op_x, op_y;
  logic [PW-1:0]          prod_d;
  logic [DB-1:0]          a0_plus_m;
  logic [W-1:0]           numer;
  logic [W-1:0]           dividend;
  logic [W-1:0]           quot;
  logic                   div_last;

  assign a0 = res_q[RB-1:0];

  // Root digit: compare the remainder against res + bit.
  assign root_sum = {1'b0, res_q} + {1'b0, bit_q};
  assign root_ge  = ({1'b0, v_q} >= root_sum);

  // One multiplier serves both d*a and m*m.
  assign op_x   = cmd_i.mul_mm ? DB'(m_q) : d_q;
  assign op_y   = cmd_i.mul_mm ? DB'(m_q) : a_q;
  assign prod_d = PW'(op_x) * PW'(op_y);

  assign a0_plus_m = DB'(a0) + DB'(m_q);
  assign numer     = W'(n_q) - W'(prod_q);
  assign dividend  = cmd_i.div_sel_a ? W'(a0_plus_m) : numer;

  sqcf_div #(
    .DIVIDEND_BITS (W),
    .DIVISOR_BITS  (DB)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (d_q),
    .quotient_o (quot),
    .last_o     (div_last)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q   <= NUMBER_BITS'(number_i);
      v_q   <= W'(NUMBER_BITS'(number_i));
      res_q <= '0;
      bit_q <= {2'b01, {(W - 2){1'b0}}};
    end else if (cmd_i.root_step) begin
      v_q   <= root_ge ? (v_q - root_sum[W-1:0]) : v_q;
      res_q <= root_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.init_rec) begin
      m_q <= '0;
      d_q <= DB'(1);
      a_q <= DB'(a0);
    end else begin
      if (cmd_i.sub_m) begin
        m_q <= RB'(prod_q - PW'(m_q));
      end
      if (cmd_i.take_d) begin
        d_q <= quot[DB-1:0];
      end
      if (cmd_i.take_a) begin
        a_q <= quot[DB-1:0];
      end
    end
    if (cmd_i.mul_da || cmd_i.mul_mm) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sat_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        count_q <= '0;
        sat_q   <= 1'b0;
      end else if (cmd_i.take_a) begin
        count_q <= count_q + PERIOD_BITS'(1);
      end
      if (cmd_i.set_sat) begin
        sat_q <= 1'b1;
      end
    end
  end

  assign status_o.root_last = bit_q[0];
  assign status_o.perfect   = (v_q == '0);
  assign status_o.div_last  = div_last;
  assign status_o.q_zero    = (quot == '0);
  assign status_o.a_end     = (quot == W'({a0, 1'b0}));
  assign status_o.cnt_full  = (count_q == PERIOD_BITS'((64'd1 << PERIOD_BITS) - 64'd2));

  assign period_o      = sqcf_pkg::PERIOD_W'(count_q);
  assign first_term_o  = sqcf_pkg::FIRST_TERM_W'(a0);
  assign status_flag_o = (v_q == '0);
  assign saturated_o   = sat_q;

endmodule

@@ rtl/sqcf_ctrl.sv @@
// Controller state machine sequencing root search, multiplies and divisions.
// Depends on sqcf_pkg for the command and status structures.
module sqcf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  sqcf_pkg::sqcf_status_t status_i,
  output sqcf_pkg::sqcf_cmd_t    cmd_o,
  output logic                   busy_o,
  output logic                   valid_o
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_ROOT     = 13'b0000000000010,
    S_CHECK    = 13'b0000000000100,
    S_MUL_DA   = 13'b0000000001000,
    S_SUB_M    = 13'b0000000010000,
    S_MUL_MM   = 13'b0000000100000,
    S_DIV_D_GO = 13'b0000001000000,
    S_DIV_D    = 13'b0000010000000,
    S_TAKE_D   = 13'b0000100000000,
    S_DIV_A_GO = 13'b0001000000000,
    S_DIV_A    = 13'b0010000000000,
    S_TAKE_A   = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (status_i.root_last) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.perfect) begin
          state_d = S_DONE;
        end else begin
          cmd_o.init_rec = 1'b1;
          state_d        = S_MUL_DA;
        end
      end
      S_MUL_DA: begin
        cmd_o.mul_da = 1'b1;
        state_d      = S_SUB_M;
      end
      S_SUB_M: begin
        cmd_o.sub_m = 1'b1;
        state_d     = S_MUL_MM;
      end
      S_MUL_MM: begin
        cmd_o.mul_mm = 1'b1;
        state_d      = S_DIV_D_GO;
      end
      S_DIV_D_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_D;
      end
      S_DIV_D: begin
        if (status_i.div_last) begin
          state_d = S_TAKE_D;
        end
      end
      S_TAKE_D: begin
        cmd_o.take_d = 1'b1;
        state_d      = status_i.q_zero ? S_DONE : S_DIV_A_GO;
      end
      S_DIV_A_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_a = 1'b1;
        state_d         = S_DIV_A;
      end
      S_DIV_A: begin
        cmd_o.div_sel_a = 1'b1;
        if (status_i.div_last) begin
          state_d = S_TAKE_A;
        end
      end
      S_TAKE_A: begin
        cmd_o.take_a = 1'b1;
        if (status_i.a_end) begin
          state_d = S_DONE;
        end else if (status_i.cnt_full) begin
          cmd_o.set_sat = 1'b1;
          state_d       = S_DONE;
        end else begin
          state_d = S_MUL_DA;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = (state_q == S_DONE);

endmodule

@@ rtl/sqrt_continued_fraction_period.sv @@
// Top level of the square-root continued-fraction period block.
// Depends on sqcf_pkg, sqcf_ctrl, sqcf_dp and sqcf_div.
//
// A transaction is accepted at a rising edge where start_i is high and busy_o is
// low; busy_o then stays high until the result has been shown. The block first
// takes the integer square root a0 one digit per cycle, RB = ceil(NUMBER_BITS/2)
// digits in all, then runs the recurrence m = d*a - m, d = (N - m*m)/d,
// a = (a0 + m)/d until a term equals 2*a0 or d comes out zero. The two divisions
// of each term go through one shared restoring divider with a W-bit dividend,
// W = 2*RB, that yields one quotient bit per cycle; one multiplier serves d*a and m*m.
// The result stands on period_o, first_term_o, status_o and saturated_o for
// exactly the one cycle in which valid_o is high; the receiver cannot stall it,
// so it must take it then. status_o high marks a perfect square (zero
// included), with period 0. When the period counter would pass 2^PERIOD_BITS - 1
// the count is clamped there and saturated_o is set. A new transaction can be
// started in the cycle after the strobe. Only the low NUMBER_BITS bits of
// number_i are used.
module sqrt_continued_fraction_period #(
  parameter int unsigned NUMBER_BITS = sqcf_pkg::NUMBER_BITS_DEF,
  parameter int unsigned PERIOD_BITS = sqcf_pkg::PERIOD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [sqcf_pkg::NUMBER_W-1:0]     number_i,
  output logic                              valid_o,
  output logic [sqcf_pkg::PERIOD_W-1:0]     period_o,
  output logic [sqcf_pkg::FIRST_TERM_W-1:0] first_term_o,
  output logic                              status_o,
  output logic                              saturated_o
);

  sqcf_pkg::sqcf_cmd_t    cmd;
  sqcf_pkg::sqcf_status_t dp_status;

  sqcf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .valid_o  (valid_o)
  );

  sqcf_dp #(
    .NUMBER_BITS (NUMBER_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .number_i      (number_i),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .period_o      (period_o),
    .first_term_o  (first_term_o),
    .status_flag_o (status_o),
    .saturated_o   (saturated_o)
  );

  // An accepted transaction keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not make the block busy");

  // The result strobe lasts one cycle and hands the block back to idle.
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> (!valid_o && !busy_o))
    else $error("result strobe not followed by idle");

  // A perfect square carries no period and no clamp.
  a_square_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o) |-> (period_o == '0 && !saturated_o))
    else $error("perfect square reported with a period");

  // Root steps, division starts and term captures are only commanded while a transaction is in progress.
  a_cmd_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.take_a || cmd.div_start || cmd.root_step) |-> busy_o)
    else $error("datapath command issued while idle");

endmodule
